// ===== hw/rtl/rbc_pkg.sv =====
package rbc_pkg;

    localparam int unsigned NUM_W      = 31;
    localparam int unsigned SB_W       = 4;
    localparam int unsigned TB_W       = 6;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned CHAR_W     = 7;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned ADDR_W     = 3;
    localparam int unsigned MUL_W      = 32;
    localparam int unsigned PROD_W     = 2 * MUL_W;
    localparam int unsigned EST_W      = 7;

    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned DEC_W      = 4;
    localparam int unsigned DEC_IDX_W  = $clog2(DEC_DIGITS);
    localparam int unsigned DEC_CNT_W  = $clog2(DEC_DIGITS + 1);

    localparam logic [SB_W-1:0] SB_RESET = SB_W'(10);
    localparam logic [SB_W-1:0] SB_MIN   = SB_W'(2);
    localparam logic [SB_W-1:0] SB_MAX   = SB_W'(10);
    localparam logic [TB_W-1:0] TB_RESET = TB_W'(16);
    localparam logic [TB_W-1:0] TB_MIN   = TB_W'(2);
    localparam logic [TB_W-1:0] TB_MAX   = TB_W'(36);
    localparam logic [TB_W-1:0] DEC_RADIX = TB_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_A_OFS = CHAR_W'(55);

    // register index, taken from the word address bit
    localparam logic REG_SOURCE_BASE = 1'b0;
    localparam logic REG_TARGET_BASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_DIGIT = 2'd1,
        ST_TOO_SMALL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_RECIP,
        S_DIV_BACK,
        S_DIV_FIX,
        S_HORN_MUL,
        S_HORN_ADD,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic [SB_W-1:0] sb;
        logic [TB_W-1:0] tb;
    } t_cfg;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } t_mul_req;

    localparam int unsigned NUM_RECIP = 37;
    localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;

    // floor(2^32 / d); quotient estimate is exact or one low
    localparam logic [MUL_W-1:0] RECIP_TAB [NUM_RECIP] = '{
        32'd0, 32'd0,
        32'(RECIP_NUM / 64'd2),  32'(RECIP_NUM / 64'd3),  32'(RECIP_NUM / 64'd4),
        32'(RECIP_NUM / 64'd5),  32'(RECIP_NUM / 64'd6),  32'(RECIP_NUM / 64'd7),
        32'(RECIP_NUM / 64'd8),  32'(RECIP_NUM / 64'd9),  32'(RECIP_NUM / 64'd10),
        32'(RECIP_NUM / 64'd11), 32'(RECIP_NUM / 64'd12), 32'(RECIP_NUM / 64'd13),
        32'(RECIP_NUM / 64'd14), 32'(RECIP_NUM / 64'd15), 32'(RECIP_NUM / 64'd16),
        32'(RECIP_NUM / 64'd17), 32'(RECIP_NUM / 64'd18), 32'(RECIP_NUM / 64'd19),
        32'(RECIP_NUM / 64'd20), 32'(RECIP_NUM / 64'd21), 32'(RECIP_NUM / 64'd22),
        32'(RECIP_NUM / 64'd23), 32'(RECIP_NUM / 64'd24), 32'(RECIP_NUM / 64'd25),
        32'(RECIP_NUM / 64'd26), 32'(RECIP_NUM / 64'd27), 32'(RECIP_NUM / 64'd28),
        32'(RECIP_NUM / 64'd29), 32'(RECIP_NUM / 64'd30), 32'(RECIP_NUM / 64'd31),
        32'(RECIP_NUM / 64'd32), 32'(RECIP_NUM / 64'd33), 32'(RECIP_NUM / 64'd34),
        32'(RECIP_NUM / 64'd35), 32'(RECIP_NUM / 64'd36)
    };

    function automatic logic [MUL_W-1:0] recip(input logic [TB_W-1:0] d);
        logic [MUL_W-1:0] r;
        r = '0;
        if (d < TB_W'(NUM_RECIP)) begin
            r = RECIP_TAB[d];
        end
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [TB_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DEC_RADIX) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_A_OFS + CHAR_W'(d);
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/rbc_cfg.sv =====
module rbc_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbc_pkg::ADDR_W-1:0]    paddr,
    input  logic [rbc_pkg::DATA_W-1:0]    pwdata,
    output logic [rbc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output rbc_pkg::t_cfg                 o_cfg
);

    logic [rbc_pkg::SB_W-1:0] r_source_base;
    logic [rbc_pkg::TB_W-1:0] r_target_base;
    logic                     wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_base <= rbc_pkg::SB_RESET;
            r_target_base <= rbc_pkg::TB_RESET;
        end else if (wr_en) begin
            if (paddr[2] == rbc_pkg::REG_SOURCE_BASE) begin
                r_source_base <= pwdata[rbc_pkg::SB_W-1:0];
            end else begin
                r_target_base <= pwdata[rbc_pkg::TB_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == rbc_pkg::REG_SOURCE_BASE) begin
            prdata = rbc_pkg::DATA_W'(r_source_base);
        end else begin
            prdata = rbc_pkg::DATA_W'(r_target_base);
        end
    end

    // out-of-range bases saturate
    always_comb begin
        o_cfg.sb = r_source_base;
        if (r_source_base < rbc_pkg::SB_MIN) begin
            o_cfg.sb = rbc_pkg::SB_MIN;
        end else if (r_source_base > rbc_pkg::SB_MAX) begin
            o_cfg.sb = rbc_pkg::SB_MAX;
        end
        o_cfg.tb = r_target_base;
        if (r_target_base < rbc_pkg::TB_MIN) begin
            o_cfg.tb = rbc_pkg::TB_MIN;
        end else if (r_target_base > rbc_pkg::TB_MAX) begin
            o_cfg.tb = rbc_pkg::TB_MAX;
        end
    end

endmodule

// ===== hw/rtl/rbc_mul.sv =====
module rbc_mul (
    input  logic                        i_clk,
    input  rbc_pkg::t_mul_req           i_req,
    output logic [rbc_pkg::PROD_W-1:0]  o_p
);

    logic [rbc_pkg::PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_p <= rbc_pkg::PROD_W'(i_req.a) * rbc_pkg::PROD_W'(i_req.b);
        end
    end

    assign o_p = r_p;

endmodule

// ===== hw/rtl/rbc_core.sv =====
module rbc_core #(
    parameter int unsigned MAX_DIGITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbc_pkg::t_cfg                 i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rbc_pkg::NUM_W-1:0]     i_encoded_number,
    output rbc_pkg::t_mul_req             o_mul,
    input  logic [rbc_pkg::PROD_W-1:0]    i_mul_p,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rbc_pkg::STATUS_W-1:0]  o_status,
    output logic [rbc_pkg::CHAR_W-1:0]    o_digit_char,
    output logic [rbc_pkg::TB_W-1:0]      o_digit_value,
    output logic [rbc_pkg::NUM_W-1:0]     o_value_decimal,
    output logic                          o_last
);

    localparam int unsigned AW = $clog2(MAX_DIGITS);
    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned NW = rbc_pkg::NUM_W;

    rbc_pkg::t_state r_state, n_state;

    logic [NW-1:0]                    r_m, n_m;
    logic [NW-1:0]                    r_q, n_q;
    logic [NW-1:0]                    r_val, n_val;
    logic                             r_conv, n_conv;
    logic [rbc_pkg::DEC_CNT_W-1:0]    r_dcnt, n_dcnt;
    logic [rbc_pkg::DEC_IDX_W-1:0]    r_hidx, n_hidx;
    logic [CW-1:0]                    r_tcnt, n_tcnt;
    logic [AW-1:0]                    r_eidx, n_eidx;
    rbc_pkg::t_status                 r_err, n_err;

    logic [rbc_pkg::DEC_W-1:0]        r_dec [rbc_pkg::DEC_DIGITS];
    logic                             dec_we;

    logic [rbc_pkg::TB_W-1:0]         mem [MAX_DIGITS];
    logic                             mem_we;
    logic                             mem_re;
    logic [rbc_pkg::TB_W-1:0]         r_rd_data;

    logic                             r_ov, n_ov;
    rbc_pkg::t_status                 r_ostat, n_ostat;
    logic [rbc_pkg::CHAR_W-1:0]       r_ochar, n_ochar;
    logic [rbc_pkg::TB_W-1:0]         r_odig, n_odig;
    logic [NW-1:0]                    r_oval, n_oval;
    logic                             r_olast, n_olast;

    logic                             in_acc;
    logic                             can_load;
    logic [rbc_pkg::TB_W-1:0]         divisor;
    logic [rbc_pkg::EST_W-1:0]        est;
    logic                             fix;
    logic [rbc_pkg::TB_W-1:0]         rem;
    logic [NW-1:0]                    quo;

    assign o_in_stall = (r_state != rbc_pkg::S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign can_load   = !r_ov || !i_out_stall;
    assign divisor    = r_conv ? i_cfg.tb : rbc_pkg::DEC_RADIX;

    // q_est * d never exceeds m; remainder estimate stays below 2*d
    assign est = rbc_pkg::EST_W'(r_m - i_mul_p[NW-1:0]);
    assign fix = (est >= rbc_pkg::EST_W'(divisor));
    assign rem = fix ? rbc_pkg::TB_W'(est - rbc_pkg::EST_W'(divisor))
                     : rbc_pkg::TB_W'(est);
    assign quo = r_q + NW'(fix);

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_q     = r_q;
        n_val   = r_val;
        n_conv  = r_conv;
        n_dcnt  = r_dcnt;
        n_hidx  = r_hidx;
        n_tcnt  = r_tcnt;
        n_eidx  = r_eidx;
        n_err   = r_err;
        dec_we  = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        o_mul   = '0;

        n_ov    = r_ov && i_out_stall;
        n_ostat = r_ostat;
        n_ochar = r_ochar;
        n_odig  = r_odig;
        n_oval  = r_oval;
        n_olast = r_olast;

        case (r_state)
            rbc_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_encoded_number < NW'(2)) begin
                        n_err   = rbc_pkg::ST_TOO_SMALL;
                        n_state = rbc_pkg::S_ERR;
                    end else begin
                        n_m     = i_encoded_number;
                        n_conv  = 1'b0;
                        n_dcnt  = '0;
                        n_state = rbc_pkg::S_DIV_RECIP;
                    end
                end
            end
            rbc_pkg::S_DIV_RECIP: begin
                o_mul.en = 1'b1;
                o_mul.a  = rbc_pkg::MUL_W'(r_m);
                o_mul.b  = rbc_pkg::recip(divisor);
                n_state  = rbc_pkg::S_DIV_BACK;
            end
            rbc_pkg::S_DIV_BACK: begin
                n_q      = i_mul_p[2*rbc_pkg::MUL_W-2 -: NW];
                o_mul.en = 1'b1;
                o_mul.a  = rbc_pkg::MUL_W'(i_mul_p[2*rbc_pkg::MUL_W-2 -: NW]);
                o_mul.b  = rbc_pkg::MUL_W'(divisor);
                n_state  = rbc_pkg::S_DIV_FIX;
            end
            rbc_pkg::S_DIV_FIX: begin
                n_m = quo;
                if (!r_conv) begin
                    if (rem[rbc_pkg::DEC_W-1:0] >= i_cfg.sb) begin
                        n_err   = rbc_pkg::ST_BAD_DIGIT;
                        n_state = rbc_pkg::S_ERR;
                    end else begin
                        dec_we = 1'b1;
                        n_dcnt = r_dcnt + rbc_pkg::DEC_CNT_W'(1);
                        if (quo == '0) begin
                            n_hidx  = r_dcnt[rbc_pkg::DEC_IDX_W-1:0];
                            n_val   = '0;
                            n_state = rbc_pkg::S_HORN_MUL;
                        end else begin
                            n_state = rbc_pkg::S_DIV_RECIP;
                        end
                    end
                end else begin
                    mem_we = 1'b1;
                    n_tcnt = r_tcnt + CW'(1);
                    if (quo == '0 || r_tcnt == CW'(MAX_DIGITS - 1)) begin
                        n_eidx  = r_tcnt[AW-1:0];
                        n_state = rbc_pkg::S_EMIT_RD;
                    end else begin
                        n_state = rbc_pkg::S_DIV_RECIP;
                    end
                end
            end
            rbc_pkg::S_HORN_MUL: begin
                o_mul.en = 1'b1;
                o_mul.a  = rbc_pkg::MUL_W'(r_val);
                o_mul.b  = rbc_pkg::MUL_W'(i_cfg.sb);
                n_state  = rbc_pkg::S_HORN_ADD;
            end
            rbc_pkg::S_HORN_ADD: begin
                n_val = i_mul_p[NW-1:0] + NW'(r_dec[r_hidx]);
                if (r_hidx == '0) begin
                    n_m     = n_val;
                    n_conv  = 1'b1;
                    n_tcnt  = '0;
                    n_state = rbc_pkg::S_DIV_RECIP;
                end else begin
                    n_hidx  = r_hidx - rbc_pkg::DEC_IDX_W'(1);
                    n_state = rbc_pkg::S_HORN_MUL;
                end
            end
            rbc_pkg::S_EMIT_RD: begin
                mem_re  = 1'b1;
                n_state = rbc_pkg::S_EMIT_OUT;
            end
            rbc_pkg::S_EMIT_OUT: begin
                if (can_load) begin
                    n_ov    = 1'b1;
                    n_ostat = rbc_pkg::ST_OK;
                    n_ochar = rbc_pkg::digit_char(r_rd_data);
                    n_odig  = r_rd_data;
                    n_oval  = r_val;
                    n_olast = (r_eidx == '0);
                    if (r_eidx == '0) begin
                        n_state = rbc_pkg::S_IDLE;
                    end else begin
                        n_eidx  = r_eidx - AW'(1);
                        n_state = rbc_pkg::S_EMIT_RD;
                    end
                end
            end
            rbc_pkg::S_ERR: begin
                if (can_load) begin
                    n_ov    = 1'b1;
                    n_ostat = r_err;
                    n_ochar = '0;
                    n_odig  = '0;
                    n_oval  = '0;
                    n_olast = 1'b1;
                    n_state = rbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbc_pkg::S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m     <= n_m;
        r_q     <= n_q;
        r_val   <= n_val;
        r_conv  <= n_conv;
        r_dcnt  <= n_dcnt;
        r_hidx  <= n_hidx;
        r_tcnt  <= n_tcnt;
        r_eidx  <= n_eidx;
        r_err   <= n_err;
        r_ostat <= n_ostat;
        r_ochar <= n_ochar;
        r_odig  <= n_odig;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (dec_we) begin
            r_dec[r_dcnt[rbc_pkg::DEC_IDX_W-1:0]] <= rem[rbc_pkg::DEC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_tcnt[AW-1:0]] <= rem;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_eidx];
        end
    end

    assign o_out_valid     = r_ov;
    assign o_status        = r_ostat;
    assign o_digit_char    = r_ochar;
    assign o_digit_value   = r_odig;
    assign o_value_decimal = r_oval;
    assign o_last          = r_olast;

endmodule

// ===== hw/rtl/radix_base_converter.sv =====
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_encoded_number
// output   | o_out_valid  | i_out_stall  | o_status, o_digit_char, o_digit_value,
//          |              |              | o_value_decimal, o_last
// config   | psel/penable | pready (=1)  | paddr, pwdata, prdata
//
// One item at a time. Each decimal split is a reciprocal multiply, a back-multiply and
// a fix step; each Horner step a multiply and an add; each division by the target base
// the same three steps; each result a read and a load, held while the output stalls;
// then idle, all paced by the single shared 32x32 multiplier. Input below two: error.
// Synchronous active-low reset; bases reset to 10 and 16.
// Output register: the next item is taken once the last result is loaded.
module radix_base_converter #(
    parameter int unsigned MAX_DIGITS = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbc_pkg::ADDR_W-1:0]    paddr,
    input  logic [rbc_pkg::DATA_W-1:0]    pwdata,
    output logic [rbc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rbc_pkg::NUM_W-1:0]     i_encoded_number,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rbc_pkg::STATUS_W-1:0]  o_status,
    output logic [rbc_pkg::CHAR_W-1:0]    o_digit_char,
    output logic [rbc_pkg::TB_W-1:0]      o_digit_value,
    output logic [rbc_pkg::NUM_W-1:0]     o_value_decimal,
    output logic                          o_last
);

    rbc_pkg::t_cfg               cfg;
    rbc_pkg::t_mul_req           mul_req;
    logic [rbc_pkg::PROD_W-1:0]  mul_p;

    rbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    rbc_mul u_mul (
        .i_clk (i_clk),
        .i_req (mul_req),
        .o_p   (mul_p)
    );

    rbc_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_encoded_number (i_encoded_number),
        .o_mul            (mul_req),
        .i_mul_p          (mul_p),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_digit_char     (o_digit_char),
        .o_digit_value    (o_digit_value),
        .o_value_decimal  (o_value_decimal),
        .o_last           (o_last)
    );

endmodule

// ===== hw/rtl/rbc_checker.sv =====
module rbc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [rbc_pkg::STATUS_W-1:0]  o_status,
    input logic [rbc_pkg::CHAR_W-1:0]    o_digit_char,
    input logic [rbc_pkg::TB_W-1:0]      o_digit_value,
    input logic [rbc_pkg::NUM_W-1:0]     o_value_decimal,
    input logic                          o_last
);

    // busy right after an item is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_digit_char) && $stable(o_digit_value)
            && $stable(o_value_decimal) && $stable(o_last))
        else $error("stalled output item changed");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != rbc_pkg::ST_OK |-> o_last && o_digit_char == '0
            && o_digit_value == '0 && o_value_decimal == '0)
        else $error("error item malformed");

    a_char_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == rbc_pkg::ST_OK
            |-> o_digit_char == rbc_pkg::digit_char(o_digit_value))
        else $error("digit character does not match digit value");

endmodule

bind radix_base_converter rbc_checker u_rbc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_digit_char    (o_digit_char),
    .o_digit_value   (o_digit_value),
    .o_value_decimal (o_value_decimal),
    .o_last          (o_last)
);

// ===== verif/radix_base_converter_test.sv =====
module radix_base_converter_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_DIGITS   = 31;
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned HOLD_AT      = 60;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned RAND_PHASES  = 7;
    localparam int unsigned PHASE_ITEMS  = 58;
    localparam longint unsigned NUM_MAX  = 64'd2147483647;
    localparam byte ASCII_ZERO = "0";
    localparam byte ASCII_A    = "A";
    localparam logic [rbc_pkg::ADDR_W-1:0] ADDR_SOURCE_BASE =
        {rbc_pkg::REG_SOURCE_BASE, 2'b00};
    localparam logic [rbc_pkg::ADDR_W-1:0] ADDR_TARGET_BASE =
        {rbc_pkg::REG_TARGET_BASE, 2'b00};

    typedef struct {
        rbc_pkg::t_status                status;
        logic [rbc_pkg::CHAR_W-1:0]      ch;
        logic [rbc_pkg::TB_W-1:0]        dval;
        logic [rbc_pkg::NUM_W-1:0]       dec;
        logic                            last;
    } t_digit_result;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [rbc_pkg::ADDR_W-1:0]          paddr = '0;
    logic [rbc_pkg::DATA_W-1:0]          pwdata = '0;
    logic [rbc_pkg::DATA_W-1:0]          prdata;
    logic                                pready;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [rbc_pkg::NUM_W-1:0]           i_encoded_number = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [rbc_pkg::STATUS_W-1:0]        o_status;
    logic [rbc_pkg::CHAR_W-1:0]          o_digit_char;
    logic [rbc_pkg::TB_W-1:0]            o_digit_value;
    logic [rbc_pkg::NUM_W-1:0]           o_value_decimal;
    logic                                o_last;

    logic [rbc_pkg::NUM_W-1:0]           pending_numbers[$];
    t_digit_result                       expected_digits[$];
    logic [rbc_pkg::SB_W-1:0]            src_base_reg = rbc_pkg::SB_RESET;
    logic [rbc_pkg::TB_W-1:0]            tgt_base_reg = rbc_pkg::TB_RESET;
    int unsigned                         send_idle_pct = 13;
    int unsigned                         recv_idle_pct = 47;
    int unsigned                         numbers_taken = 0;
    int unsigned                         hold_left = 0;
    bit                                  hold_done = 1'b0;
    int unsigned                         fail_count = 0;
    int unsigned                         cycle_count = 0;

    radix_base_converter #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_encoded_number (i_encoded_number),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_digit_char     (o_digit_char),
        .o_digit_value    (o_digit_value),
        .o_value_decimal  (o_value_decimal),
        .o_last           (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // expected digit stream for one number under the current bases
    function automatic void predict_digits(input logic [rbc_pkg::NUM_W-1:0] num);
        int unsigned     sb;
        int unsigned     tb;
        longint unsigned m;
        longint unsigned val;
        longint unsigned w;
        int unsigned     digs[$];
        bit              bad;
        t_digit_result   r;
        sb = 32'(src_base_reg);
        tb = 32'(tgt_base_reg);
        if (sb < rbc_pkg::SB_MIN) sb = 32'(rbc_pkg::SB_MIN);
        if (sb > rbc_pkg::SB_MAX) sb = 32'(rbc_pkg::SB_MAX);
        if (tb < rbc_pkg::TB_MIN) tb = 32'(rbc_pkg::TB_MIN);
        if (tb > rbc_pkg::TB_MAX) tb = 32'(rbc_pkg::TB_MAX);
        r.ch = '0;
        r.dval = '0;
        r.dec = '0;
        r.last = 1'b1;
        if (num < 2) begin
            r.status = rbc_pkg::ST_TOO_SMALL;
            expected_digits.push_back(r);
            return;
        end
        bad = 1'b0;
        for (m = num; m > 0; m = m / 10) begin
            if (m % 10 >= sb) bad = 1'b1;
        end
        if (bad) begin
            r.status = rbc_pkg::ST_BAD_DIGIT;
            expected_digits.push_back(r);
            return;
        end
        val = 0;
        w = 1;
        for (m = num; m > 0; m = m / 10) begin
            val += w * (m % 10);
            w *= sb;
        end
        val &= NUM_MAX;
        for (m = val; m > 0 && digs.size() < MAX_DIGITS; m = m / tb) begin
            digs.push_front(32'(m % tb));
        end
        if (digs.size() == 0) digs.push_back(0);
        for (int k = 0; k < digs.size(); k++) begin
            r.status = rbc_pkg::ST_OK;
            r.dval = rbc_pkg::TB_W'(digs[k]);
            r.ch = (digs[k] < 10) ? rbc_pkg::CHAR_W'(ASCII_ZERO + digs[k])
                                  : rbc_pkg::CHAR_W'(ASCII_A + digs[k] - 10);
            r.dec = rbc_pkg::NUM_W'(val);
            r.last = (k == digs.size() - 1);
            expected_digits.push_back(r);
        end
    endfunction

    function automatic logic [rbc_pkg::NUM_W-1:0] random_number(input int unsigned sb);
        longint unsigned n;
        int unsigned     kind;
        int unsigned     nd;
        int unsigned     pos;
        longint unsigned p10;
        if (sb < rbc_pkg::SB_MIN) sb = 32'(rbc_pkg::SB_MIN);
        if (sb > rbc_pkg::SB_MAX) sb = 32'(rbc_pkg::SB_MAX);
        kind = $urandom_range(99);
        if (kind < 12) return rbc_pkg::NUM_W'($urandom);
        if (kind < 20) return rbc_pkg::NUM_W'($urandom_range(0, 20));
        nd = $urandom_range(1, 10);
        n = 0;
        for (int i = 0; i < nd; i++) begin
            n = n * 10 + $urandom_range(sb - 1);
        end
        if (n > NUM_MAX) n = n % 64'd1_000_000_000;
        // broken: one digit position forced to a random decimal digit
        if (kind >= 88) begin
            pos = $urandom_range(nd - 1);
            p10 = 1;
            for (int i = 0; i < pos; i++) p10 *= 10;
            n = n - ((n / p10) % 10) * p10 + $urandom_range(9) * p10;
            if (n > NUM_MAX) n = n % 64'd1_000_000_000;
        end
        return rbc_pkg::NUM_W'(n);
    endfunction

    task automatic write_reg(input logic [rbc_pkg::ADDR_W-1:0] addr,
                             input logic [rbc_pkg::DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr[2] == rbc_pkg::REG_SOURCE_BASE) begin
            src_base_reg = data[rbc_pkg::SB_W-1:0];
        end else begin
            tgt_base_reg = data[rbc_pkg::TB_W-1:0];
        end
    endtask

    task automatic set_bases(input logic [rbc_pkg::DATA_W-1:0] sb,
                             input logic [rbc_pkg::DATA_W-1:0] tb);
        write_reg(ADDR_SOURCE_BASE, sb);
        write_reg(ADDR_TARGET_BASE, tb);
    endtask

    task automatic drain;
        do @(posedge i_clk);
        while (pending_numbers.size() != 0 || i_in_valid || expected_digits.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic check_result;
        t_digit_result e;
        if (expected_digits.size() == 0) begin
            $error("result with nothing expected: status %0d char %0d", o_status, o_digit_char);
            fail_count++;
            return;
        end
        e = expected_digits.pop_front();
        if (o_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, o_status);
            fail_count++;
        end
        if (o_digit_char !== e.ch) begin
            $error("digit_char: expected %0d, got %0d", e.ch, o_digit_char);
            fail_count++;
        end
        if (o_digit_value !== e.dval) begin
            $error("digit_value: expected %0d, got %0d", e.dval, o_digit_value);
            fail_count++;
        end
        if (o_value_decimal !== e.dec) begin
            $error("value_decimal: expected %0d, got %0d", e.dec, o_value_decimal);
            fail_count++;
        end
        if (o_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, o_last);
            fail_count++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_digits(i_encoded_number);
                numbers_taken <= numbers_taken + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (pending_numbers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_encoded_number <= pending_numbers.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back the block up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) check_result();
            if (!hold_done && numbers_taken >= HOLD_AT) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_out_stall <= 1'b1;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [rbc_pkg::DATA_W-1:0] sb;
        logic [rbc_pkg::DATA_W-1:0] tb;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_bases(10, 16);
        pending_numbers = '{0, 1, 2, 15, 16, 255, 31'd2147483647, 31'd1073741824};
        drain();
        set_bases(2, 2);
        pending_numbers = '{31'd1111111111, 31'd1000000000, 10, 12, 0};
        drain();
        set_bases(8, 36);
        pending_numbers = '{31'd1777777777, 31'd1234567, 8, 43};
        drain();
        set_bases(10, 2);
        pending_numbers = '{31'd2147483647};
        drain();
        // out-of-range register values clamp
        set_bases(0, 63);
        pending_numbers = '{101, 1, 1101};
        drain();
        set_bases(15, 1);
        pending_numbers = '{31'd999999999, 7};
        drain();
        set_bases(10, 10);
        pending_numbers = '{31'd1999999999};
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 13;
            end else if (ph == 5) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sb = ($urandom_range(99) < 70) ? $urandom_range(2, 10) : $urandom_range(0, 15);
            tb = ($urandom_range(99) < 70) ? $urandom_range(2, 36) : $urandom_range(0, 63);
            sb[rbc_pkg::DATA_W-1:rbc_pkg::SB_W] =
                (rbc_pkg::DATA_W - rbc_pkg::SB_W)'($urandom);
            tb[rbc_pkg::DATA_W-1:rbc_pkg::TB_W] =
                (rbc_pkg::DATA_W - rbc_pkg::TB_W)'($urandom);
            set_bases(sb, tb);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pending_numbers.push_back(random_number(32'(src_base_reg)));
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rbc_pkg.sv
hw/rtl/rbc_cfg.sv
hw/rtl/rbc_mul.sv
hw/rtl/rbc_core.sv
hw/rtl/radix_base_converter.sv
hw/rtl/rbc_checker.sv
verif/radix_base_converter_test.sv
